// ===== hw/rtl/lcdtrk_pkg.sv =====
// Shared types, constants and helpers of the character-LCD cursor tracker.
package lcdtrk_pkg;

  // DDRAM line length of the controller; addresses wrap at this value.
  localparam int DdramLineLen = 40;

  // Bus bytes one command can cause, and the depth of the command queue.
  localparam int MaxBytes   = 4;
  localparam int SlotIdxW   = $clog2(MaxBytes);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Address sums reach at most 63 + 2 * DdramLineLen - 1 and need this
  // many conditional subtractions to fold back into the line.
  localparam int SumW     = 9;
  localparam int ModSteps = (63 + 2 * DdramLineLen - 1) / DdramLineLen;

  localparam logic signed [SumW-1:0] LineLenSum    = SumW'(DdramLineLen);
  localparam logic signed [6:0]      LineLenScroll = 7'(DdramLineLen);
  localparam logic [5:0]             LineLenCol    = 6'(DdramLineLen);

  // Character codes with a line-control meaning.
  localparam logic [7:0] ChCr = 8'd13;
  localparam logic [7:0] ChLf = 8'd10;

  // HD44780 command bytes.
  localparam logic [7:0] OpClear       = 8'h01;
  localparam logic [7:0] OpHome        = 8'h02;
  localparam logic [7:0] OpDispCtrl    = 8'h08;
  localparam logic [7:0] OpScrollLeft  = 8'h18;
  localparam logic [7:0] OpScrollRight = 8'h1C;
  localparam logic [7:0] OpSetDdram    = 8'h80;
  localparam logic [7:0] OpRowOdd      = 8'h40;
  localparam logic [2:0] DispOnMask    = 3'b100;

  typedef enum logic [2:0] {
    CmdWrite       = 3'd0,
    CmdSetCursor   = 3'd1,
    CmdScrollLeft  = 3'd2,
    CmdScrollRight = 3'd3,
    CmdClear       = 3'd4,
    CmdHome        = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    CfgNumCols     = 3'd0,
    CfgNumLines    = 3'd1,
    CfgTwoChips    = 3'd2,
    CfgRightToLeft = 3'd3,
    CfgDisplayCtrl = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [5:0] num_cols;
    logic [2:0] num_lines;
    logic       two_chips;
    logic       right_to_left;
    logic [2:0] display_ctrl;
  } cfg_t;

  typedef struct packed {
    logic       is_data;
    logic       chip_sel;
    logic [7:0] bus_byte;
  } bus_slot_t;

  // All bytes of one command plus the cursor position it leaves.
  typedef struct packed {
    logic [SlotIdxW-1:0]          last_idx;
    bus_slot_t [MaxBytes-1:0]     slots;
    logic [5:0]                   cur_col;
    logic [1:0]                   cur_row;
  } burst_t;

  function automatic bus_slot_t mk_slot(logic is_data, logic chip, logic [7:0] data);
    bus_slot_t s;
    s.is_data  = is_data;
    s.chip_sel = chip;
    s.bus_byte = data;
    return s;
  endfunction

  // Folds a signed address sum into 0 .. DdramLineLen-1.
  function automatic logic [5:0] ddram_wrap(logic signed [SumW-1:0] sum);
    logic signed [SumW-1:0] v;
    v = sum;
    if (v < 0) v = v + LineLenSum;
    for (int i = 0; i < ModSteps; i++) begin
      if (v >= LineLenSum) v = v - LineLenSum;
    end
    return v[5:0];
  endfunction

endpackage

// ===== hw/rtl/char_lcd_cursor_tracker.sv =====
// Top level of the character-LCD cursor tracker: configuration registers and the three stages.
//
//   Channel   Direction  Handshake              Payload
//   in        sink       in_valid_i/in_ready_o  cmd_i, char_code_i, target_col_i, target_row_i
//   out       source     out_valid_o/out_ready_i is_data_o, chip_sel_o, bus_byte_o, last_o,
//                                               cur_col_o, cur_row_o
//   cfg       sink       cfg_we_i (no wait)     cfg_addr_i, cfg_wdata_i
//
// The front end takes each command, updates the cursor state and writes all bytes
// it causes into a two-entry burst queue; a command causes 0 to 4 bytes, and one
// that causes none pushes nothing. The sender puts out one byte per cycle while
// out_ready_i is high. The first byte is offered once the burst has passed through
// the queue and into the sender's burst register. Back-pressure on the output fills
// the queue, and in_ready_o drops only when the queue is full. Reset clears the
// cursor state, the queue and the sender, and loads the configuration defaults.
module char_lcd_cursor_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_addr_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] char_code_i,
  input  logic [5:0] target_col_i,
  input  logic [1:0] target_row_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_data_o,
  output logic       chip_sel_o,
  output logic [7:0] bus_byte_o,
  output logic       last_o,
  output logic [5:0] cur_col_o,
  output logic [1:0] cur_row_o
);
  import lcdtrk_pkg::*;

  cfg_t   cfg_q;
  logic   q_room, q_push, q_avail, q_pop;
  burst_t push_burst, pop_burst;

  // Configuration registers. Writes to indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_cols      <= 6'd16;
      cfg_q.num_lines     <= 3'd2;
      cfg_q.two_chips     <= 1'b0;
      cfg_q.right_to_left <= 1'b0;
      cfg_q.display_ctrl  <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CfgNumCols:     cfg_q.num_cols      <= cfg_wdata_i;
        CfgNumLines:    cfg_q.num_lines     <= cfg_wdata_i[2:0];
        CfgTwoChips:    cfg_q.two_chips     <= cfg_wdata_i[0];
        CfgRightToLeft: cfg_q.right_to_left <= cfg_wdata_i[0];
        CfgDisplayCtrl: cfg_q.display_ctrl  <= cfg_wdata_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // The front end classifies each command and builds its complete byte burst.
  lcdtrk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .target_col_i(target_col_i),
    .target_row_i(target_row_i),
    .room_i      (q_room),
    .push_o      (q_push),
    .burst_o     (push_burst)
  );

  // The queue decouples command intake from the slower byte-by-byte output.
  lcdtrk_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push_burst),
    .room_o     (q_room),
    .pop_i      (q_pop),
    .avail_o    (q_avail),
    .pop_data_o (pop_burst)
  );

  // The sender walks through the bytes of one burst at a time.
  lcdtrk_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (q_avail),
    .burst_i    (pop_burst),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_data_o  (is_data_o),
    .chip_sel_o (chip_sel_o),
    .bus_byte_o (bus_byte_o),
    .last_o     (last_o),
    .cur_col_o  (cur_col_o),
    .cur_row_o  (cur_row_o)
  );

  // A burst is never written into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> q_room)
    else $error("burst pushed into a full queue");

  // Once a byte that is not the last one is taken, the next byte of the burst follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside a burst");

  // Every DDRAM address byte points inside one DDRAM line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && !is_data_o && bus_byte_o[7]
                   |-> bus_byte_o[5:0] < LineLenCol)
    else $error("DDRAM address beyond the line length");

endmodule

// ===== hw/rtl/lcdtrk_front.sv =====
// Front end: accepts commands, updates the cursor state and builds the byte burst.
module lcdtrk_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcdtrk_pkg::cfg_t     cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           cmd_i,
  input  logic [7:0]           char_code_i,
  input  logic [5:0]           target_col_i,
  input  logic [1:0]           target_row_i,
  input  logic                 room_i,
  output logic                 push_o,
  output lcdtrk_pkg::burst_t   burst_o
);
  import lcdtrk_pkg::*;

  logic [5:0]        col_q, col_d;
  logic [1:0]        row_q, row_d;
  logic              pend_q, pend_d;
  logic signed [6:0] scroll_q, scroll_d;
  logic              half_q, half_d;

  logic [5:0] eff_cols;
  logic [2:0] eff_lines;
  logic       accept;

  // Set-cursor address path, shared by set cursor and the realign before a write.
  logic                   sc_is_set;
  logic [5:0]             sc_col;
  logic [1:0]             sc_row_raw, sc_row;
  logic [5:0]             sc_base;
  logic                   sc_target;
  logic signed [SumW-1:0] sc_sum;
  logic [7:0]             sc_addr;

  bus_slot_t [MaxBytes-1:0] slots;
  logic [SlotIdxW:0]        n;
  logic                     h;
  logic [6:0]               x;
  logic [2:0]               y;
  logic signed [6:0]        sc_step;

  assign in_ready_o = room_i;
  assign accept     = in_valid_i && room_i;

  always_comb begin
    if (cfg_i.num_cols == 6'd0)            eff_cols = 6'd1;
    else if (cfg_i.num_cols > LineLenCol)  eff_cols = LineLenCol;
    else                                   eff_cols = cfg_i.num_cols;
    if (cfg_i.num_lines == 3'd0)           eff_lines = 3'd1;
    else if (cfg_i.num_lines > 3'd4)       eff_lines = 3'd4;
    else                                   eff_lines = cfg_i.num_lines;
  end

  always_comb begin
    sc_is_set  = (cmd_i == CmdSetCursor);
    sc_col     = sc_is_set ? target_col_i : col_q;
    sc_row_raw = sc_is_set ? target_row_i : row_q;
    if ({1'b0, sc_row_raw} >= eff_lines) sc_row = 2'(eff_lines - 3'd1);
    else                                 sc_row = sc_row_raw;
    sc_base   = (!cfg_i.two_chips && sc_row[1]) ? eff_cols : 6'd0;
    sc_target = cfg_i.two_chips && sc_row[1];
    sc_sum    = $signed({3'b000, sc_col}) + $signed({3'b000, sc_base}) + SumW'(scroll_q);
    sc_addr   = OpSetDdram | (sc_row[0] ? OpRowOdd : 8'h00) | {2'b00, ddram_wrap(sc_sum)};
  end

  always_comb begin
    slots    = '0;
    n        = '0;
    h        = cfg_i.two_chips ? half_q : 1'b0;
    col_d    = col_q;
    row_d    = row_q;
    pend_d   = pend_q;
    scroll_d = scroll_q;
    x        = '0;
    y        = '0;
    sc_step  = '0;
    case (cmd_e'(cmd_i))
      CmdWrite, CmdSetCursor: begin
        if (sc_is_set || scroll_q != 7'sd0 || pend_q) begin
          if (cfg_i.two_chips && h != sc_target) begin
            slots[n[SlotIdxW-1:0]] = mk_slot(1'b0, h,
                                             OpDispCtrl | {5'b0, cfg_i.display_ctrl & DispOnMask});
            n = n + 1'b1;
            slots[n[SlotIdxW-1:0]] = mk_slot(1'b0, sc_target,
                                             OpDispCtrl | {5'b0, cfg_i.display_ctrl});
            n = n + 1'b1;
          end
          h = sc_target;
          slots[n[SlotIdxW-1:0]] = mk_slot(1'b0, h, sc_addr);
          n      = n + 1'b1;
          col_d  = sc_col;
          row_d  = sc_row;
          pend_d = 1'b0;
        end
        if (!sc_is_set) begin
          if (char_code_i != ChCr && char_code_i != ChLf) begin
            slots[n[SlotIdxW-1:0]] = mk_slot(1'b1, h, char_code_i);
            n = n + 1'b1;
          end
          pend_d = 1'b0;
          y      = {1'b0, row_d};
          if (!cfg_i.right_to_left) begin
            x = {1'b0, col_d} + 7'd1;
            if (char_code_i == ChCr || x >= {1'b0, eff_cols}) begin
              x      = '0;
              y      = y + 3'd1;
              pend_d = 1'b1;
            end
          end else begin
            if (char_code_i == ChLf || col_d == 6'd0) begin
              x      = {1'b0, eff_cols - 6'd1};
              y      = y + 3'd1;
              pend_d = 1'b1;
            end else begin
              x = {1'b0, col_d - 6'd1};
            end
          end
          if (y >= eff_lines) y = '0;
          col_d = x[5:0];
          row_d = y[1:0];
        end
      end
      CmdScrollLeft, CmdScrollRight: begin
        slots[0] = mk_slot(1'b0, 1'b0,
                           (cmd_i == CmdScrollLeft) ? OpScrollLeft : OpScrollRight);
        slots[1] = mk_slot(1'b0, 1'b1,
                           (cmd_i == CmdScrollLeft) ? OpScrollLeft : OpScrollRight);
        n = cfg_i.two_chips ? (SlotIdxW+1)'(2) : (SlotIdxW+1)'(1);
        if (cmd_i == CmdScrollLeft) begin
          sc_step = scroll_q + 7'sd1;
          if (sc_step >= LineLenScroll) sc_step = sc_step - LineLenScroll;
        end else begin
          sc_step = scroll_q - 7'sd1;
          if (sc_step <= -LineLenScroll) sc_step = sc_step + LineLenScroll;
        end
        scroll_d = sc_step;
      end
      CmdClear, CmdHome: begin
        slots[0] = mk_slot(1'b0, 1'b0, (cmd_i == CmdClear) ? OpClear : OpHome);
        slots[1] = mk_slot(1'b0, 1'b1, (cmd_i == CmdClear) ? OpClear : OpHome);
        n = cfg_i.two_chips ? (SlotIdxW+1)'(2) : (SlotIdxW+1)'(1);
        if (cfg_i.two_chips && h) begin
          slots[n[SlotIdxW-1:0]] = mk_slot(1'b0, 1'b1,
                                           OpDispCtrl | {5'b0, cfg_i.display_ctrl & DispOnMask});
          n = n + 1'b1;
          slots[n[SlotIdxW-1:0]] = mk_slot(1'b0, 1'b0,
                                           OpDispCtrl | {5'b0, cfg_i.display_ctrl});
          n = n + 1'b1;
        end
        h        = 1'b0;
        col_d    = '0;
        row_d    = '0;
        pend_d   = 1'b0;
        scroll_d = '0;
      end
      default: begin
      end
    endcase
    half_d = h;
  end

  assign push_o           = accept && (n != '0);
  assign burst_o.slots    = slots;
  assign burst_o.last_idx = SlotIdxW'(n - 1'b1);
  assign burst_o.cur_col  = col_d;
  assign burst_o.cur_row  = row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= 1'b0;
      scroll_q <= '0;
      half_q   <= 1'b0;
    end else if (accept) begin
      col_q    <= col_d;
      row_q    <= row_d;
      pend_q   <= pend_d;
      scroll_q <= scroll_d;
      half_q   <= half_d;
    end
  end

endmodule

// ===== hw/rtl/lcdtrk_queue.sv =====
// Short FIFO of byte bursts between the front end and the bus sender.
module lcdtrk_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lcdtrk_pkg::burst_t   push_data_i,
  output logic                 room_o,
  input  logic                 pop_i,
  output logic                 avail_o,
  output lcdtrk_pkg::burst_t   pop_data_o
);
  import lcdtrk_pkg::*;

  burst_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  function automatic logic [QPtrW-1:0] ptr_next(logic [QPtrW-1:0] p);
    return (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign room_o     = (cnt_q != QCntW'(QueueDepth));
  assign avail_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/lcdtrk_back.sv =====
// Bus sender: presents the bytes of one burst, one transaction per cycle while out_ready_i is high.
module lcdtrk_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 avail_i,
  input  lcdtrk_pkg::burst_t   burst_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 is_data_o,
  output logic                 chip_sel_o,
  output logic [7:0]           bus_byte_o,
  output logic                 last_o,
  output logic [5:0]           cur_col_o,
  output logic [1:0]           cur_row_o
);
  import lcdtrk_pkg::*;

  burst_t              burst_q;
  logic [SlotIdxW-1:0] idx_q;
  logic                busy_q;
  logic                fire, fin;
  bus_slot_t           slot;

  assign slot        = burst_q.slots[idx_q];
  assign out_valid_o = busy_q;
  assign is_data_o   = slot.is_data;
  assign chip_sel_o  = slot.chip_sel;
  assign bus_byte_o  = slot.bus_byte;
  assign last_o      = (idx_q == burst_q.last_idx);
  assign cur_col_o   = burst_q.cur_col;
  assign cur_row_o   = burst_q.cur_row;

  assign fire  = busy_q && out_ready_i;
  assign fin   = fire && last_o;
  assign pop_o = avail_i && (!busy_q || fin);

  always_ff @(posedge clk_i) begin
    if (pop_o) burst_q <= burst_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fin) begin
      busy_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

endmodule

// ===== tb/sv/char_lcd_cursor_tracker_test.sv =====
// Self-checking testbench of the character-LCD cursor tracker with its own cursor predictor.
module char_lcd_cursor_tracker_test;
  import lcdtrk_pkg::*;

  // Command codes 6 and 7 are not part of the command set; the block must drop them.
  localparam logic [2:0] CmdSpare6 = 3'd6;
  localparam logic [2:0] CmdSpare7 = 3'd7;
  // Register index past the end of the register list; writes to it are ignored.
  localparam logic [2:0] CfgSpare  = 3'd7;

  // One bus byte as it should leave the block, with the cursor the command leaves.
  typedef struct packed {
    logic       is_data;
    logic       chip_sel;
    logic [7:0] bus_byte;
    logic       last;
    logic [5:0] cur_col;
    logic [1:0] cur_row;
  } lcd_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_addr_i;
  logic [5:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [2:0] cmd_i;
  logic [7:0] char_code_i;
  logic [5:0] target_col_i;
  logic [1:0] target_row_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       is_data_o;
  logic       chip_sel_o;
  logic [7:0] bus_byte_o;
  logic       last_o;
  logic [5:0] cur_col_o;
  logic [1:0] cur_row_o;

  char_lcd_cursor_tracker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .char_code_i  (char_code_i),
    .target_col_i (target_col_i),
    .target_row_i (target_row_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .is_data_o    (is_data_o),
    .chip_sel_o   (chip_sel_o),
    .bus_byte_o   (bus_byte_o),
    .last_o       (last_o),
    .cur_col_o    (cur_col_o),
    .cur_row_o    (cur_row_o)
  );

  always #5 clk_i = ~clk_i;

  // Bytes still owed by the block, oldest first, and the bytes of the command
  // currently being predicted.
  lcd_byte_t lcd_bytes_due[$];
  lcd_byte_t cmd_bytes[$];
  int        err_count = 0;

  // Idle control. When idle_on is low neither side inserts random gaps. hold_ask hands
  // a long output hold-off to the receiver process, which counts it down itself.
  bit        idle_on   = 1'b1;
  int        hold_ask  = 0;
  bit        hold_taken = 1'b0;
  int        hold_left = 0;
  int        stall_left = 0;

  // Shadow copy of the configuration registers, at their reset values.
  logic [5:0] cols_reg    = 6'd16;
  logic [2:0] lines_reg   = 3'd2;
  logic       split_chips = 1'b0;
  logic       rtl_dir     = 1'b0;
  logic [2:0] disp_bits   = 3'd4;

  // Shadow cursor state. The scroll shift is signed and stays within one
  // DDRAM line either way.
  int   trk_col     = 0;
  int   trk_row     = 0;
  bit   wrap_due    = 1'b0;
  int   shift_amt   = 0;
  logic cursor_half = 1'b0;

  // The registers are used clamped to the range that the hardware supports.
  function automatic int line_cols();
    if (cols_reg < 1) return 1;
    if (cols_reg > DdramLineLen) return DdramLineLen;
    return int'(cols_reg);
  endfunction

  function automatic int line_count();
    if (lines_reg < 1) return 1;
    if (lines_reg > 4) return 4;
    return int'(lines_reg);
  endfunction

  function automatic logic live_chip();
    return split_chips ? cursor_half : 1'b0;
  endfunction

  function automatic void note_byte(logic is_data, logic chip, logic [7:0] value);
    lcd_byte_t b;
    b = '0;
    b.is_data  = is_data;
    b.chip_sel = chip;
    b.bus_byte = value;
    cmd_bytes.push_back(b);
  endfunction

  // Moving the visible cursor to the other controller: cursor off on the chip
  // being left (display bit kept), then the full display control on the new one.
  function automatic void hand_cursor_to(logic target);
    note_byte(1'b0, cursor_half, OpDispCtrl | {5'b0, disp_bits & DispOnMask});
    cursor_half = target;
    note_byte(1'b0, cursor_half, OpDispCtrl | {5'b0, disp_bits});
  endfunction

  function automatic void place_cursor(int col, int row);
    int   base;
    int   sum;
    int   addr;
    logic target;
    if (row >= line_count()) row = line_count() - 1;
    trk_row  = row & 3;
    trk_col  = col & 63;
    wrap_due = 1'b0;
    // On a single chip, rows 2 and 3 continue lines 0 and 1 after num_cols.
    base = (!split_chips && row >= 2) ? line_cols() : 0;
    sum  = trk_col + base + shift_amt;
    addr = sum % DdramLineLen;
    if (addr < 0) addr += DdramLineLen;
    target = split_chips ? row[1] : 1'b0;
    if (split_chips && cursor_half != target) hand_cursor_to(target);
    else cursor_half = target;
    note_byte(1'b0, live_chip(),
              OpSetDdram | ((row & 1) ? OpRowOdd : 8'h00) | 8'(addr));
  endfunction

  function automatic void send_to_all(logic [7:0] value);
    note_byte(1'b0, 1'b0, value);
    if (split_chips) note_byte(1'b0, 1'b1, value);
  endfunction

  function automatic void write_char(logic [7:0] ch);
    int cols;
    int x;
    int y;
    cols = line_cols();
    // A scrolled display or a pending wrap needs the address set again first.
    if (shift_amt != 0 || wrap_due) place_cursor(trk_col, trk_row);
    y = trk_row;
    if (ch != ChCr && ch != ChLf) note_byte(1'b1, live_chip(), ch);
    wrap_due = 1'b0;
    if (!rtl_dir) begin
      x = trk_col + 1;
      if (ch == ChCr || x >= cols) begin
        x = 0;
        y++;
        wrap_due = 1'b1;
      end
    end else begin
      if (ch == ChLf || trk_col == 0) begin
        x = cols - 1;
        y++;
        wrap_due = 1'b1;
      end else begin
        x = trk_col - 1;
      end
    end
    if (y >= line_count()) y = 0;
    trk_col = x & 63;
    trk_row = y & 3;
  endfunction

  function automatic void clear_or_home(logic [7:0] op);
    send_to_all(op);
    if (split_chips && cursor_half != 1'b0) hand_cursor_to(1'b0);
    cursor_half = 1'b0;
    trk_col     = 0;
    trk_row     = 0;
    wrap_due    = 1'b0;
    shift_amt   = 0;
  endfunction

  // Works out every bus byte one accepted command causes and queues them.
  function automatic void predict_lcd_bytes(logic [2:0] cmd, logic [7:0] ch,
                                            logic [5:0] tcol, logic [1:0] trow);
    lcd_byte_t b;
    cmd_bytes.delete();
    if (!split_chips) cursor_half = 1'b0;
    case (cmd)
      CmdWrite:     write_char(ch);
      CmdSetCursor: place_cursor(int'(tcol), int'(trow));
      CmdScrollLeft: begin
        send_to_all(OpScrollLeft);
        shift_amt++;
        if (shift_amt >= DdramLineLen) shift_amt -= DdramLineLen;
      end
      CmdScrollRight: begin
        send_to_all(OpScrollRight);
        shift_amt--;
        if (shift_amt <= -DdramLineLen) shift_amt += DdramLineLen;
      end
      CmdClear:     clear_or_home(OpClear);
      CmdHome:      clear_or_home(OpHome);
      default: ;
    endcase
    for (int i = 0; i < cmd_bytes.size(); i++) begin
      b = cmd_bytes[i];
      b.last    = (i == cmd_bytes.size() - 1);
      b.cur_col = 6'(trk_col);
      b.cur_row = 2'(trk_row);
      lcd_bytes_due.push_back(b);
    end
  endfunction

  function automatic void compare_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endfunction

  // Offers one command and waits for its transaction. The payload is changed
  // at a falling edge only, and valid stays high into the next command unless
  // an idle burst falls between them.
  task automatic issue_command(logic [2:0] cmd, logic [7:0] ch,
                               logic [5:0] tcol, logic [1:0] trow);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    cmd_i        = cmd;
    char_code_i  = ch;
    target_col_i = tcol;
    target_row_i = trow;
    do @(posedge clk_i); while (!in_ready_o);
    predict_lcd_bytes(cmd, ch, tcol, trow);
  endtask

  // Lets the block run dry. Commands without bytes may still be in the front
  // end when the last owed byte has left, so the task waits on after that.
  task automatic settle();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    while (lcd_bytes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(logic [2:0] idx, logic [5:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = idx;
    cfg_wdata_i = value;
    @(posedge clk_i);
    case (idx)
      CfgNumCols:     cols_reg    = value;
      CfgNumLines:    lines_reg   = value[2:0];
      CfgTwoChips:    split_chips = value[0];
      CfgRightToLeft: rtl_dir     = value[0];
      CfgDisplayCtrl: disp_bits   = value[2:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic program_display(logic [5:0] cols, logic [2:0] lines, logic split,
                                 logic rtl, logic [2:0] disp);
    write_reg(CfgNumCols, cols);
    write_reg(CfgNumLines, 6'(lines));
    write_reg(CfgTwoChips, 6'(split));
    write_reg(CfgRightToLeft, 6'(rtl));
    write_reg(CfgDisplayCtrl, 6'(disp));
  endtask

  // A random command, mostly character writes. Columns mostly land inside
  // the configured line, but the whole 6-bit field is used now and then.
  task automatic issue_random_command();
    int         pick;
    logic [2:0] cmd;
    logic [7:0] ch;
    logic [5:0] tcol;
    logic [1:0] trow;
    pick = $urandom_range(0, 99);
    ch   = 8'($urandom_range(0, 255));
    tcol = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                       : 6'($urandom_range(0, line_cols() - 1));
    trow = 2'($urandom_range(0, 3));
    if (pick < 50) begin
      cmd = CmdWrite;
      if (pick < 5) ch = ChCr;
      else if (pick < 10) ch = ChLf;
    end else if (pick < 68) cmd = CmdSetCursor;
    else if (pick < 78) cmd = CmdScrollLeft;
    else if (pick < 88) cmd = CmdScrollRight;
    else if (pick < 93) cmd = CmdClear;
    else if (pick < 97) cmd = CmdHome;
    else cmd = (pick[0]) ? CmdSpare7 : CmdSpare6;
    issue_command(cmd, ch, tcol, trow);
  endtask

  // Reset configuration: plain characters at both ends of the byte range, the
  // two line controls with and without a wrap pending, a set cursor beyond the
  // last line, both scrolls, clear, home and the two unused codes.
  task automatic test_single_chip_basics();
    issue_command(CmdWrite, 8'h41, 6'd0, 2'd0);
    issue_command(CmdWrite, 8'hFF, 6'd0, 2'd0);
    issue_command(CmdWrite, 8'h00, 6'd0, 2'd0);
    issue_command(CmdWrite, ChCr, 6'd0, 2'd0);
    issue_command(CmdWrite, ChLf, 6'd0, 2'd0);
    issue_command(CmdSetCursor, 8'h00, 6'h3F, 2'd3);
    issue_command(CmdScrollLeft, 8'h00, 6'd0, 2'd0);
    issue_command(CmdScrollRight, 8'h00, 6'd0, 2'd0);
    issue_command(CmdClear, 8'h00, 6'd0, 2'd0);
    issue_command(CmdHome, 8'h00, 6'd0, 2'd0);
    issue_command(CmdSpare6, 8'hFF, 6'h3F, 2'd3);
    issue_command(CmdSpare7, 8'h00, 6'd0, 2'd0);
    settle();
  endtask

  // Register values outside the supported range are clamped; a write to an
  // index past the list must change nothing.
  task automatic test_config_extremes();
    program_display(6'd0, 3'd0, 1'b0, 1'b0, 3'd7);
    write_reg(CfgSpare, 6'h3F);
    issue_command(CmdWrite, 8'h55, 6'd0, 2'd0);
    issue_command(CmdWrite, 8'hAA, 6'd0, 2'd0);
    program_display(6'h3F, 3'd7, 1'b0, 1'b1, 3'd0);
    issue_command(CmdSetCursor, 8'h00, 6'd0, 2'd3);
    issue_command(CmdWrite, 8'h78, 6'd0, 2'd0);
    issue_command(CmdWrite, ChLf, 6'd0, 2'd0);
    settle();
  endtask

  // Two controllers: the cursor crosses to the second half and back, a
  // scrolled write re-addresses, and clear from the second half hands back.
  task automatic test_two_chip_handoff();
    program_display(6'd20, 3'd4, 1'b1, 1'b0, 3'd7);
    issue_command(CmdSetCursor, 8'h00, 6'd5, 2'd2);
    issue_command(CmdWrite, 8'h61, 6'd0, 2'd0);
    issue_command(CmdScrollLeft, 8'h00, 6'd0, 2'd0);
    issue_command(CmdWrite, 8'h62, 6'd0, 2'd0);
    issue_command(CmdClear, 8'h00, 6'd0, 2'd0);
    issue_command(CmdSetCursor, 8'h00, 6'd39, 2'd3);
    issue_command(CmdHome, 8'h00, 6'd0, 2'd0);
    settle();
  endtask

  // The receiver holds off for a long stretch while commands keep coming, so
  // the burst queue fills and the input side stalls.
  task automatic test_output_backpressure();
    program_display(6'd16, 3'd2, 1'b1, 1'b0, 3'd6);
    idle_on  = 1'b0;
    hold_ask = 80;
    repeat (12) issue_random_command();
    settle();
    idle_on  = 1'b1;
  endtask

  // Random phases under several configurations. One phase scrolls far enough
  // that the offset wraps around the line; the last phase runs without idling.
  task automatic test_random_mix();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_display(6'd1, 3'd1, 1'b0, 1'b1, 3'd0);
        1: program_display(6'd40, 3'd4, 1'b1, 1'b0, 3'd7);
        default: program_display(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 3'($urandom_range(0, 7)));
      endcase
      idle_on = (phase < 4);
      if (phase == 2) begin
        for (int i = 0; i < 48; i++) begin
          if (i % 8 == 7) issue_command(CmdWrite, 8'($urandom_range(0, 255)), 6'd0, 2'd0);
          else issue_command(CmdScrollLeft, 8'h00, 6'd0, 2'd0);
        end
      end
      repeat (30) issue_random_command();
    end
    settle();
  endtask

  // Output side: ready changes at falling edges. The long hold-off wins over
  // the random stall bursts, which only run while idling is enabled.
  always @(negedge clk_i) begin
    if (hold_ask > 0 && !hold_taken) begin
      hold_left  = hold_ask;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i = 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left  = $urandom_range(1, 11) - 1;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Each output transaction is compared with the oldest owed byte.
  always @(posedge clk_i) begin
    lcd_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (lcd_bytes_due.size() == 0) begin
        $display("%0t: unexpected bus byte, expected none, actual %0h", $time, bus_byte_o);
        err_count++;
      end else begin
        want = lcd_bytes_due.pop_front();
        compare_field("is_data", want.is_data, is_data_o);
        compare_field("chip_sel", want.chip_sel, chip_sel_o);
        compare_field("bus_byte", want.bus_byte, bus_byte_o);
        compare_field("last", want.last, last_o);
        compare_field("cur_col", want.cur_col, cur_col_o);
        compare_field("cur_row", want.cur_row, cur_row_o);
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_addr_i   = CfgNumCols;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    cmd_i        = CmdWrite;
    char_code_i  = '0;
    target_col_i = '0;
    target_row_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_single_chip_basics();
    test_config_extremes();
    test_two_chip_handoff();
    test_output_backpressure();
    test_random_mix();

    settle();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Far beyond the slowest correct run: every command at four bytes, each
  // byte waiting out the longest stall, plus gaps, settling and the hold-off.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
